/* rtl/rgb_box_mean_filter_3x3_core_assert.svh */
// Assertion macros for the 3x3 box mean filter core.
`ifndef RGB_BOX_MEAN_FILTER_3X3_CORE_ASSERT_SVH
`define RGB_BOX_MEAN_FILTER_3X3_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RBM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define RBM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBM_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define RBM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/rbm_pkg.sv */
// Shared types and constants for the 3x3 box mean filter core.
`timescale 1ns / 1ps
package rbm_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;
    localparam int CFG_DATA_W        = 12;
    localparam int CFG_INDEX_W       = 1;
    localparam int ROW_W             = 12;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RESET   = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } rbm_reg_t;

    typedef logic [23:0] pixel_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       filler;
    } rbm_in_t;

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } rbm_out_t;

    // classification of one transaction, handed from front to back
    typedef struct packed {
        logic   valid;
        logic   pass;
        logic   last;
        pixel_t pix;
    } rbm_desc_t;

endpackage

/* rtl/rbm_queue.sv */
// Short descriptor queue between the classifying front and the filter back end.
`timescale 1ns / 1ps
module rbm_queue import rbm_pkg::*; #(
    parameter int COL_W = $clog2(MAX_WIDTH_DEFAULT)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [COL_W-1:0] push_k,
    input  rbm_desc_t        push_desc,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [COL_W-1:0] head_k,
    output rbm_desc_t        head_desc
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [COL_W-1:0] k_mem [QUEUE_DEPTH];
    rbm_desc_t        desc_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_k    = k_mem[rd_ptr_reg];
    assign head_desc = desc_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= PTR_W'((CNT_W'(wr_ptr_reg) + CNT_W'(1)) % QUEUE_DEPTH);
            end
            if (pop) begin
                rd_ptr_reg <= PTR_W'((CNT_W'(rd_ptr_reg) + CNT_W'(1)) % QUEUE_DEPTH);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            k_mem[wr_ptr_reg]    <= push_k;
            desc_mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* rtl/rbm_front.sv */
// Front end: configuration, position counters and classification of each transaction.
`timescale 1ns / 1ps
module rbm_front import rbm_pkg::*; #(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEFAULT,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rbm_in_t                s_data,
    output logic                   push,
    output logic [COL_W-1:0]       push_k,
    output rbm_desc_t              push_desc,
    input  logic                   q_full
);

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

    function automatic logic [CNT_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve < CMP_W'(3)) begin
            ve = CMP_W'(3);
        end else if (ve > CMP_W'(MAX_WIDTH)) begin
            ve = CMP_W'(MAX_WIDTH);
        end
        return CNT_W'(ve);
    endfunction

    logic [CNT_W-1:0] w_use_reg;
    logic [ROW_W-1:0] h_use_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;

    logic [COL_W-1:0] k;
    logic [CNT_W-1:0] k_inc;
    logic [CNT_W-1:0] oc_inc;
    logic [ROW_W-1:0] h_m1;
    logic             k_wrap;
    logic             oc_wrap;
    logic             valid;
    logic             border;
    logic             last;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        k       = (CNT_W'(in_col_reg) < w_use_reg) ? in_col_reg : '0;
        k_inc   = CNT_W'(k) + CNT_W'(1);
        oc_inc  = CNT_W'(out_col_reg) + CNT_W'(1);
        h_m1    = h_use_reg - ROW_W'(1);
        k_wrap  = (k_inc >= w_use_reg);
        oc_wrap = (oc_inc >= w_use_reg);
        valid   = (in_row_reg >= ROW_W'(2)) || ((in_row_reg == ROW_W'(1)) && (k != '0));
        border  = (out_row_reg == '0) || (out_row_reg >= h_m1) ||
                  (out_col_reg == '0) || oc_wrap;
        last    = valid && (out_row_reg == h_m1) && (oc_inc == w_use_reg);

        push_k          = k;
        push_desc.valid = valid;
        push_desc.pass  = (k == '0) || border;
        push_desc.last  = last;
        push_desc.pix   = s_data.filler ? '0 : {s_data.red_in, s_data.green_in, s_data.blue_in};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_use_reg   <= clamp_width(LINE_WIDTH_RESET);
            h_use_reg   <= FRAME_HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LINE_WIDTH: begin
                    w_use_reg <= clamp_width(cfg_wdata);
                end
                REG_FRAME_HEIGHT: begin
                    h_use_reg <= (cfg_wdata < CFG_DATA_W'(3)) ? ROW_W'(3) : ROW_W'(cfg_wdata);
                end
                default: begin
                end
            endcase
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (push) begin
            if (last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                if (k_wrap) begin
                    in_col_reg <= '0;
                    if (in_row_reg < h_use_reg) begin
                        in_row_reg <= in_row_reg + ROW_W'(1);
                    end
                end else begin
                    in_col_reg <= COL_W'(k_inc);
                end
                if (valid) begin
                    if (oc_wrap) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_reg <= COL_W'(oc_inc);
                    end
                end
            end
        end
    end

endmodule

/* rtl/rbm_back.sv */
// Back end: line stores, 3x3 window, channel sums and divide by nine.
`timescale 1ns / 1ps
module rbm_back import rbm_pkg::*; #(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEFAULT,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  logic [COL_W-1:0] q_head_k,
    input  rbm_desc_t        q_head_desc,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output rbm_out_t         m_data
);

    localparam int              SUM_W       = 12;
    localparam int              RECIP_W     = 13;
    localparam int              PROD_W      = SUM_W + RECIP_W;
    localparam int              RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    pixel_t line_upper_mem  [MAX_WIDTH];
    pixel_t line_middle_mem [MAX_WIDTH];

    logic             adv;
    logic             wr_en;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             m_valid_reg;
    rbm_desc_t        d1_reg;
    rbm_desc_t        d2_reg;
    rbm_desc_t        d3_reg;
    logic [COL_W-1:0] k1_reg;
    pixel_t           top_rd_reg;
    pixel_t           mid_rd_reg;
    pixel_t           top_fwd_reg;
    pixel_t           mid_fwd_reg;
    logic             fwd_reg;
    pixel_t           top_cur;
    pixel_t           mid_cur;
    pixel_t           win_reg [3][3];
    logic [SUM_W-1:0] sum_next [3];
    logic [SUM_W-1:0] sum_reg [3];
    pixel_t           center_reg;
    logic [PROD_W-1:0] prod [3];
    logic [7:0]       mean [3];
    rbm_out_t         out_next;
    rbm_out_t         m_data_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign q_pop   = adv && !q_empty;
    assign wr_en   = adv && v1_reg;
    assign top_cur = fwd_reg ? top_fwd_reg : top_rd_reg;
    assign mid_cur = fwd_reg ? mid_fwd_reg : mid_rd_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_upper_mem[k1_reg]  <= mid_cur;
            line_middle_mem[k1_reg] <= d1_reg.pix;
        end
        if (q_pop) begin
            top_rd_reg <= line_upper_mem[q_head_k];
            mid_rd_reg <= line_middle_mem[q_head_k];
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_next[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    sum_next[ch] = sum_next[ch] + SUM_W'(win_reg[r][c][8*ch +: 8]);
                end
            end
            prod[ch] = PROD_W'(sum_reg[ch]) * PROD_W'(RECIP_NINE);
            mean[ch] = prod[ch][RECIP_SHIFT +: 8];
        end
    end

    always_comb begin
        out_next = '0;
        if (d3_reg.valid) begin
            out_next.pixel_valid = 1'b1;
            out_next.frame_last  = d3_reg.last;
            if (d3_reg.pass) begin
                out_next.red_out   = center_reg[23:16];
                out_next.green_out = center_reg[15:8];
                out_next.blue_out  = center_reg[7:0];
            end else begin
                out_next.red_out   = mean[2];
                out_next.green_out = mean[1];
                out_next.blue_out  = mean[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            if (adv) begin
                v1_reg      <= !q_empty;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                m_valid_reg <= v3_reg;
            end
            // same column read while the previous transaction writes it
            if (q_pop) begin
                fwd_reg <= v1_reg && (q_head_k == k1_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            top_fwd_reg <= mid_cur;
            mid_fwd_reg <= d1_reg.pix;
        end
        if (adv) begin
            d1_reg     <= q_head_desc;
            k1_reg     <= q_head_k;
            d2_reg     <= d1_reg;
            d3_reg     <= d2_reg;
            sum_reg    <= sum_next;
            center_reg <= win_reg[1][1];
            m_data_reg <= out_next;
        end
        if (wr_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_cur;
            win_reg[1][2] <= mid_cur;
            win_reg[2][2] <= d1_reg.pix;
        end
    end

endmodule

/* rtl/rgb_box_mean_filter_3x3_core.sv */
// Pipeline: a popped transaction moves through d1_reg, d2_reg and d3_reg into the output register.
// Throughput: one transaction per cycle while m_ready does not stall the output, set by the back end pipeline
// (line-store read, window shift, channel adder tree, reciprocal multiply).
// Each frame gives W+1 non-pixel results first, then W*H pixels.
// Reset (aresetn low, synchronous): counters, queue and pipeline cleared,
// 640x480 configured; line stores keep their contents.
`timescale 1ns / 1ps
`include "rgb_box_mean_filter_3x3_core_assert.svh"
module rgb_box_mean_filter_3x3_core import rbm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rbm_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rbm_out_t               m_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             q_push;
    logic [COL_W-1:0] q_push_k;
    rbm_desc_t        q_push_desc;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    logic [COL_W-1:0] q_head_k;
    rbm_desc_t        q_head_desc;

    rbm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (q_push),
        .push_k    (q_push_k),
        .push_desc (q_push_desc),
        .q_full    (q_full)
    );

    rbm_queue #(
        .COL_W (COL_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_k    (q_push_k),
        .push_desc (q_push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_k    (q_head_k),
        .head_desc (q_head_desc)
    );

    rbm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head_k    (q_head_k),
        .q_head_desc (q_head_desc),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    `RBM_ASSERT_NEXT(a_push_fills_queue, aclk, aresetn, s_valid && s_ready, !q_empty, "accepted transaction missing from queue")
    `RBM_ASSERT_SAME(a_stall_blocks_pop, aclk, aresetn, m_valid && !m_ready, !q_pop, "queue popped while output stalled")
    `RBM_ASSERT_SAME(a_delay_is_zero, aclk, aresetn, m_valid && !m_data.pixel_valid, (m_data.red_out == 8'd0) && (m_data.green_out == 8'd0) && (m_data.blue_out == 8'd0) && !m_data.frame_last, "non-pixel result carries data")
    `RBM_ASSERT_SAME(a_last_is_pixel, aclk, aresetn, m_valid && m_data.frame_last, m_data.pixel_valid, "frame end on a non-pixel result")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 RGB box mean filter core.
module tb;
import rbm_pkg::*;

localparam int MAX_W         = MAX_WIDTH_DEFAULT;
localparam int CYCLE_LIMIT   = 500000;
localparam int SETTLE_CYCLES = 12;

class mean_filter_scoreboard;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pixel_t                upper_line [MAX_W];
    pixel_t                middle_line [MAX_W];
    pixel_t                window_pix [3][3];
    int unsigned           col_in;
    int unsigned           row_in;
    int unsigned           col_out;
    logic [ROW_W-1:0]      row_out;
    rbm_out_t              expected_pixels [$];
    int                    error_count;

    function new();
        width_reg   = LINE_WIDTH_RESET;
        height_reg  = FRAME_HEIGHT_RESET;
        error_count = 0;
        foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        foreach (window_pix[r, c]) window_pix[r][c] = '0;
        restart();
    endfunction

    function void restart();
        col_in  = 0;
        row_in  = 0;
        col_out = 0;
        row_out = '0;
    endfunction

    function void write_reg(rbm_reg_t idx, logic [CFG_DATA_W-1:0] val);
        if (idx == REG_LINE_WIDTH) begin
            width_reg = val;
        end else begin
            height_reg = val;
        end
        restart();
    endfunction

    function logic [7:0] channel_mean(int sh);
        int unsigned sum = 0;
        foreach (window_pix[r, c]) sum += (window_pix[r][c] >> sh) & 24'hFF;
        return 8'(sum / 9);
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    // predict the result caused by one accepted transaction
    function void take_pixel(rbm_in_t t);
        int unsigned w;
        int unsigned h;
        int unsigned k;
        pixel_t      pix;
        pixel_t      top;
        pixel_t      mid;
        pixel_t      prior;
        pixel_t      value;
        logic        valid;
        logic        last;
        logic        border;
        rbm_out_t    want;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        h = (height_reg < 3) ? 3 : height_reg;
        k = (col_in < w) ? col_in : 0;
        pix = t.filler ? pixel_t'(0) : {t.red_in, t.green_in, t.blue_in};

        top            = upper_line[k];
        mid            = middle_line[k];
        upper_line[k]  = mid;
        middle_line[k] = pix;

        prior = window_pix[1][2];
        for (int r = 0; r < 3; r++) begin
            window_pix[r][0] = window_pix[r][1];
            window_pix[r][1] = window_pix[r][2];
        end
        window_pix[0][2] = top;
        window_pix[1][2] = mid;
        window_pix[2][2] = pix;

        valid = (row_in >= 2) || (row_in == 1 && k >= 1);
        value = '0;
        last  = 1'b0;
        if (valid) begin
            border = (row_out == 0) || (row_out >= h - 1) || (col_out == 0) ||
                     (col_out >= w - 1);
            if (k == 0) begin
                value = prior;
            end else if (border) begin
                value = window_pix[1][1];
            end else begin
                value = {channel_mean(16), channel_mean(8), channel_mean(0)};
            end
            last = (row_out == h - 1) && (col_out == w - 1);
        end

        want.pixel_valid = valid;
        want.red_out     = value[23:16];
        want.green_out   = value[15:8];
        want.blue_out    = value[7:0];
        want.frame_last  = last;
        expected_pixels.push_back(want);

        if (k + 1 >= w) begin
            col_in = 0;
            if (row_in < h) row_in++;
        end else begin
            col_in = k + 1;
        end
        if (valid) begin
            if (col_out + 1 >= w) begin
                col_out = 0;
                row_out = row_out + 1'b1;
            end else begin
                col_out++;
            end
        end
        if (last) restart();
    endfunction

    function void flag(string what, rbm_out_t want, rbm_out_t got);
        error_count++;
        if (error_count <= 10) begin
            $display("%s: exp v=%0b rgb=%02h_%02h_%02h l=%0b, got v=%0b rgb=%02h_%02h_%02h l=%0b",
                     what, want.pixel_valid, want.red_out, want.green_out, want.blue_out,
                     want.frame_last, got.pixel_valid, got.red_out, got.green_out,
                     got.blue_out, got.frame_last);
        end
    endfunction

    function void check_pixel(rbm_out_t got);
        rbm_out_t want;
        if (expected_pixels.size() == 0) begin
            flag("result with nothing outstanding", '0, got);
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_valid !== want.pixel_valid || got.red_out !== want.red_out ||
            got.green_out !== want.green_out || got.blue_out !== want.blue_out ||
            got.frame_last !== want.frame_last) begin
            flag("pixel mismatch", want, got);
        end
    endfunction
endclass

logic                   aclk      = 1'b0;
logic                   aresetn   = 1'b0;
logic                   cfg_we    = 1'b0;
logic [CFG_INDEX_W-1:0] cfg_index = REG_LINE_WIDTH;
logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
logic                   s_valid   = 1'b0;
logic                   s_ready;
rbm_in_t                s_data    = '0;
logic                   m_valid;
logic                   m_ready   = 1'b0;
rbm_out_t               m_data;

int send_idle   = 0;
int sink_idle   = 0;
int cycle_count = 0;

mean_filter_scoreboard sb = new();

rgb_box_mean_filter_3x3_core DUT (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

always begin
    aclk = 1'b1;
    #5;
    aclk = 1'b0;
    #5;
end

always @(posedge aclk) begin
    m_ready <= ($urandom_range(99) >= sink_idle);
end

always @(posedge aclk) begin
    if (aresetn) begin
        if (s_valid && s_ready) sb.take_pixel(s_data);
        if (m_valid && m_ready) sb.check_pixel(m_data);
    end
end

always @(posedge aclk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
    end
end

function automatic rbm_in_t make_item(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic fill);
    rbm_in_t t;
    t.red_in   = r;
    t.green_in = g;
    t.blue_in  = b;
    t.filler   = fill;
    return t;
endfunction

function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
        0:       return 8'h00;
        1:       return 8'hFF;
        default: return 8'($urandom_range(255));
    endcase
endfunction

function automatic rbm_in_t rand_item(int filler_pct);
    return make_item(rand_channel(), rand_channel(), rand_channel(),
                     $urandom_range(99) < filler_pct);
endfunction

task automatic send_pixel(rbm_in_t t);
    while ($urandom_range(99) < send_idle) begin
        s_valid <= 1'b0;
        @(posedge aclk);
    end
    s_valid <= 1'b1;
    s_data  <= t;
    @(posedge aclk);
    while (!s_ready) @(posedge aclk);
endtask

// hold off until every outstanding result has arrived
task automatic settle();
    s_valid <= 1'b0;
    @(posedge aclk);
    while (sb.pending() != 0) @(posedge aclk);
    repeat (SETTLE_CYCLES) @(posedge aclk);
endtask

task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_WIDTH;
    cfg_wdata <= w;
    sb.write_reg(REG_LINE_WIDTH, w);
    @(posedge aclk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    sb.write_reg(REG_FRAME_HEIGHT, h);
    @(posedge aclk);
    cfg_we <= 1'b0;
endtask

// full frames: random pixels, then the drain tail of mostly filler
task automatic send_frames(int w, int h, int count);
    int pixels;
    pixels = w * h;
    for (int f = 0; f < count; f++) begin
        for (int i = 0; i < pixels; i++) begin
            if (f == 0 && i == pixels / 2) settle();
            send_pixel(rand_item(5));
        end
        for (int i = 0; i <= w; i++) send_pixel(rand_item(90));
    end
    settle();
endtask

task automatic send_stream(int count, int filler_pct);
    for (int i = 0; i < count; i++) begin
        if (i == count / 2) settle();
        send_pixel(rand_item(filler_pct));
    end
    settle();
endtask

initial begin
    repeat (10) @(posedge aclk);
    aresetn <= 1'b1;

    send_idle = 22;
    sink_idle = 66;
    configure(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) send_pixel(make_item(8'hFF, 8'hFF, 8'hFF, 1'b0));
    for (int i = 0; i < 4; i++) send_pixel(make_item(8'hFF, 8'hFF, 8'hFF, 1'b1));
    for (int i = 0; i < 9; i++) begin
        if (i == 7) begin
            send_pixel(make_item(8'hFF, 8'hFF, 8'hFF, 1'b1));
        end else begin
            send_pixel(make_item(8'(255 - 28 * i), 8'(31 * i),
                                 (i % 2 == 1) ? 8'h55 : 8'hAA, 1'b0));
        end
    end
    for (int i = 0; i < 4; i++) send_pixel(make_item(8'h00, 8'h00, 8'h00, 1'b1));
    settle();

    configure(12'd0, 12'd4095);
    send_stream(200, 10);
    configure(12'd4, 12'd0);
    send_frames(4, 3, 10);
    configure(12'd5, 12'd7);
    send_frames(5, 7, 6);

    send_idle = 66;
    sink_idle = 22;
    configure(12'd40, 12'd6);
    send_frames(40, 6, 1);
    configure(12'd4095, 12'd2);
    send_stream(100, 50);
    configure(12'd1, 12'd3);
    send_frames(3, 3, 15);

    send_idle = 0;
    sink_idle = 0;
    configure(12'd640, 12'd480);
    send_stream(150, 5);
    configure(12'd7, 12'd5);
    send_frames(7, 5, 6);
    configure(12'd3, 12'd4);
    send_frames(3, 4, 10);

    if (sb.error_count == 0 && sb.pending() == 0) begin
        $display("PASS");
    end else begin
        $display("FAIL");
    end
    $finish;
end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rbm_pkg.sv
rtl/rbm_queue.sv
rtl/rbm_front.sv
rtl/rbm_back.sv
rtl/rgb_box_mean_filter_3x3_core.sv
verif/tb.sv
